// File: hdl/wwr_pkg.sv
package wwr_pkg;

	// Widths fixed by the transaction fields
	localparam int COL_W      = 6;
	localparam int LINE_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Default sizing
	localparam int MAX_COLUMNS_DEF = 40;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int NUM_SLOTS       = 6;

	// Register reset values
	localparam logic [5:0]  WRAP_WIDTH_RST = 6'd40;
	localparam logic [1:0]  MODE_RST       = 2'd0;
	localparam logic [15:0] LINE_LIMIT_RST = 16'd100;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd2;

	// Modes
	localparam logic [1:0] MODE_PLAIN        = 2'd0;
	localparam logic [1:0] MODE_CLEAR_ON_MSG = 2'd1;
	localparam logic [1:0] MODE_NL_AT_END    = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_CLEARED = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// Character codes
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_N          = 8'h6E;
	localparam logic [7:0] CH_LEAD_PASS  = 8'hC2;
	localparam logic [7:0] CH_LEAD_SHIFT = 8'hC3;
	localparam logic [7:0] LEAD_OFFSET   = 8'h40;
	localparam logic [7:0] CH_PRINT_MIN  = 8'd32;

	typedef enum logic [1:0] {
		LEAD_NONE  = 2'd0,
		LEAD_PASS  = 2'd1,
		LEAD_SHIFT = 2'd2
	} lead_t;

	typedef enum logic [2:0] {
		OP_NOP       = 3'd0,
		OP_CHAR      = 3'd1,
		OP_CLEAR     = 3'd2,
		OP_MSG_CLEAR = 3'd3,
		OP_END       = 3'd4
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] ch;
		logic       fin;
	} op_t;

	typedef struct packed {
		logic [COL_W-1:0]  eff_width;
		logic [1:0]        mode;
		logic [LINE_W-1:0] line_limit;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] text_byte;
		logic       first_of_message;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [LINE_W-1:0] line_number;
		logic [COL_W-1:0]  column;
		logic [7:0]        char_code;
		logic [LINE_W-1:0] oldest_line;
		logic              last;
	} out_t;

endpackage

// File: hdl/text_console_word_wrapper.sv
// Text console word wrapper.
// Input channel (in_valid / in_ready / in_item): one transaction per text byte with its
// first/last-of-message marks, or a clear command. Output channel (out_valid / out_ready /
// out_item): cell writes, new-line, cleared and message-done events; out_item.last marks
// the final event caused by an input transaction. Some bytes (a lead byte, a held
// backslash) cause no event at all.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes wrap_width, mode or
// line_limit; write only while the block is idle.
// Timing: the front part classifies a byte in its accept cycle and hands one to five
// operations to a four-entry queue, one per cycle while the queue is not full. The back
// part takes the operations in order; when a word is committed it emits a wrap line if
// the word does not fit, then the word's characters, and each transaction ends with a
// closing step. Each event is held in a register until it is known whether it is the
// last event of its transaction.
// Reset: registers return to width 40, plain mode, limit 100; line indexes to zero; no
// lead or backslash pending; the word store needs no clearing pass.
// Stall: when out_ready is low the output register holds, the back part stops, the
// queue fills and in_ready drops.
module text_console_word_wrapper #(
	parameter int MAX_COLUMNS = wwr_pkg::MAX_COLUMNS_DEF,
	parameter int QUEUE_DEPTH = wwr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wwr_pkg::in_t                        in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wwr_pkg::out_t                       out_item,
	input  logic                                cfg_wr_en,
	input  logic [wwr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wwr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [5:0]   wrap_width_q;
	logic [1:0]   mode_q;
	logic [15:0]  line_limit_q;

	wwr_pkg::cfg_t  cfg;
	wwr_pkg::op_t   op_in;
	wwr_pkg::op_t   op_out;
	logic           op_push;
	logic           op_pop;
	logic           q_full;
	logic           q_empty;

	// Configuration registers: a write to an unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= wwr_pkg::WRAP_WIDTH_RST;
			mode_q       <= wwr_pkg::MODE_RST;
			line_limit_q <= wwr_pkg::LINE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wwr_pkg::REG_WRAP_WIDTH: wrap_width_q <= cfg_data[5:0];
				wwr_pkg::REG_MODE:       mode_q       <= cfg_data[1:0];
				wwr_pkg::REG_LINE_LIMIT: line_limit_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the wrap width into 1 .. MAX_COLUMNS
	always_comb begin
		if (wrap_width_q == 6'd0) begin
			cfg.eff_width = wwr_pkg::COL_W'(1);
		end else if ({1'b0, wrap_width_q} > 7'(MAX_COLUMNS)) begin
			cfg.eff_width = wwr_pkg::COL_W'(MAX_COLUMNS);
		end else begin
			cfg.eff_width = wrap_width_q;
		end
		cfg.mode       = mode_q;
		cfg.line_limit = line_limit_q;
	end

	// Front: fold leads and escapes, split each transaction into operations
	wwr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg),
		.op       (op_in),
		.op_push  (op_push),
		.q_full   (q_full)
	);

	// Queue decouples classification from layout
	wwr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_in),
		.pop    (op_pop),
		.rdata  (op_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: word store, wrapping and event generation
	wwr_back #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.op_valid  (!q_empty),
		.op        (op_out),
		.op_pop    (op_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: hdl/wwr_front.sv
module wwr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wwr_pkg::in_t      in_item,
	input  wwr_pkg::cfg_t     cfg,
	output wwr_pkg::op_t      op,
	output logic              op_push,
	input  logic              q_full
);

	localparam int NS = wwr_pkg::NUM_SLOTS;
	localparam int SW = $clog2(NS);
	localparam int SLOT_FLUSH = 0;
	localparam int SLOT_MSG   = 1;
	localparam int SLOT_ESC   = 2;
	localparam int SLOT_BYTE  = 3;
	localparam int SLOT_EOL   = 4;
	localparam int SLOT_TAIL  = 5;

	wwr_pkg::op_t     slot_q [NS];
	logic [NS-1:0]    mask_q;
	wwr_pkg::lead_t   lead_q;
	logic             bsl_q;

	wwr_pkg::op_t     slot_n [NS];
	logic [NS-1:0]    mask_n;
	wwr_pkg::lead_t   lead_v;
	logic             bsl_v;
	logic             handled;
	logic [SW-1:0]    sel;
	logic             have;
	logic             accept;

	function automatic logic [7:0] fold_char(wwr_pkg::lead_t lead, logic [7:0] b);
		return (lead == wwr_pkg::LEAD_SHIFT) ? b + wwr_pkg::LEAD_OFFSET : b;
	endfunction

	// Classify one transaction into its list of operations
	always_comb begin
		lead_v  = lead_q;
		bsl_v   = bsl_q;
		handled = 1'b0;
		mask_n  = '0;
		for (int i = 0; i < NS; i++) begin
			slot_n[i] = '{code: wwr_pkg::OP_NOP, ch: 8'd0, fin: 1'b0};
		end
		if (in_item.cmd) begin
			slot_n[SLOT_TAIL] = '{code: wwr_pkg::OP_CLEAR, ch: 8'd0, fin: 1'b1};
			mask_n[SLOT_TAIL] = 1'b1;
		end else begin
			if (in_item.first_of_message && bsl_v) begin
				bsl_v = 1'b0;
				slot_n[SLOT_FLUSH] = '{code: wwr_pkg::OP_CHAR,
					ch: fold_char(lead_v, wwr_pkg::CH_BSLASH), fin: 1'b0};
				mask_n[SLOT_FLUSH] = 1'b1;
				lead_v = wwr_pkg::LEAD_NONE;
			end
			if (in_item.first_of_message && cfg.mode == wwr_pkg::MODE_CLEAR_ON_MSG) begin
				slot_n[SLOT_MSG] = '{code: wwr_pkg::OP_MSG_CLEAR, ch: 8'd0, fin: 1'b0};
				mask_n[SLOT_MSG] = 1'b1;
			end
			if (bsl_v) begin
				bsl_v = 1'b0;
				if (in_item.text_byte == wwr_pkg::CH_N) begin
					slot_n[SLOT_ESC] = '{code: wwr_pkg::OP_CHAR, ch: wwr_pkg::CH_LF,
						fin: 1'b0};
					handled = 1'b1;
				end else begin
					slot_n[SLOT_ESC] = '{code: wwr_pkg::OP_CHAR,
						ch: fold_char(lead_v, wwr_pkg::CH_BSLASH), fin: 1'b0};
					lead_v = wwr_pkg::LEAD_NONE;
				end
				mask_n[SLOT_ESC] = 1'b1;
			end
			if (!handled) begin
				if (in_item.text_byte == wwr_pkg::CH_BSLASH && !in_item.end_of_message) begin
					bsl_v = 1'b1;
				end else if (lead_v == wwr_pkg::LEAD_NONE &&
					in_item.text_byte == wwr_pkg::CH_LEAD_PASS) begin
					lead_v = wwr_pkg::LEAD_PASS;
				end else if (lead_v == wwr_pkg::LEAD_NONE &&
					in_item.text_byte == wwr_pkg::CH_LEAD_SHIFT) begin
					lead_v = wwr_pkg::LEAD_SHIFT;
				end else begin
					slot_n[SLOT_BYTE] = '{code: wwr_pkg::OP_CHAR,
						ch: fold_char(lead_v, in_item.text_byte), fin: 1'b0};
					mask_n[SLOT_BYTE] = 1'b1;
					lead_v = wwr_pkg::LEAD_NONE;
				end
			end
			if (in_item.end_of_message && cfg.mode == wwr_pkg::MODE_NL_AT_END) begin
				slot_n[SLOT_EOL] = '{code: wwr_pkg::OP_CHAR, ch: wwr_pkg::CH_LF, fin: 1'b0};
				mask_n[SLOT_EOL] = 1'b1;
			end
			slot_n[SLOT_TAIL] = '{code: in_item.end_of_message ? wwr_pkg::OP_END :
				wwr_pkg::OP_NOP, ch: 8'd0, fin: 1'b1};
			mask_n[SLOT_TAIL] = 1'b1;
		end
	end

	// Pick the oldest outstanding operation
	always_comb begin
		sel  = '0;
		have = 1'b0;
		for (int i = 0; i < NS; i++) begin
			if (mask_q[i] && !have) begin
				sel  = SW'(i);
				have = 1'b1;
			end
		end
	end

	assign op      = slot_q[sel];
	assign op_push = have && !q_full;
	assign in_ready = (mask_q == '0) ||
		(op_push && ((mask_q & (mask_q - NS'(1))) == '0));
	assign accept  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			lead_q <= wwr_pkg::LEAD_NONE;
			bsl_q  <= 1'b0;
		end else if (accept) begin
			mask_q <= mask_n;
			lead_q <= lead_v;
			bsl_q  <= bsl_v;
		end else if (op_push) begin
			mask_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= slot_n;
		end
	end

endmodule

// File: hdl/wwr_fifo.sv
module wwr_fifo #(
	parameter int DEPTH = wwr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wwr_pkg::op_t  wdata,
	input  logic          pop,
	output wwr_pkg::op_t  rdata,
	output logic          full,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wwr_pkg::op_t   entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hdl/wwr_back.sv
module wwr_back #(
	parameter int MAX_COLUMNS = wwr_pkg::MAX_COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wwr_pkg::cfg_t  cfg,
	input  logic           op_valid,
	input  wwr_pkg::op_t   op,
	output logic           op_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output wwr_pkg::out_t  out_item
);

	localparam int CW = wwr_pkg::COL_W;
	localparam int LW = wwr_pkg::LINE_W;
	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	typedef enum logic [4:0] {
		S_FETCH  = 5'b00001,
		S_CHECK  = 5'b00010,
		S_STREAM = 5'b00100,
		S_AFTER  = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		AFT_NONE  = 2'd0,
		AFT_OPEN  = 2'd1,
		AFT_SPACE = 2'd2
	} aft_t;

	state_t         state_q, state_d;
	aft_t           aft_q, aft_d;
	logic           fin_q, fin_d;
	logic [CW-1:0]  wl_q, wl_d;
	logic [CW-1:0]  line_q, line_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic [LW-1:0]  newest_q, newest_d;
	logic [LW-1:0]  oldest_q, oldest_d;

	logic [7:0]     word_mem [MAX_COLUMNS];
	logic [7:0]     rd_data_q;
	logic           mem_we;
	logic [CW-1:0]  wl_inc;

	wwr_pkg::out_t  hold_q;
	logic           hold_valid_q;
	wwr_pkg::out_t  out_q;
	logic           out_valid_q;

	wwr_pkg::out_t  gen_item;
	logic           gen;
	logic           gen_fire;
	logic           fin_fire;
	logic           move;
	logic           out_free;
	logic           can_step;

	logic [LW-1:0]  newest_inc;
	logic [LW-1:0]  limit;
	logic [LW:0]    kept_count;
	logic [LW-1:0]  oldest_trim;
	logic [CW:0]    fit_sum;

	assign out_free  = !out_valid_q || out_ready;
	assign can_step  = !hold_valid_q || out_free;
	assign gen_fire  = gen && can_step;
	assign fin_fire  = (state_q == S_FIN) && can_step;
	assign move      = hold_valid_q && out_free && (gen_fire || fin_fire);

	assign newest_inc  = newest_q + LW'(1);
	assign limit       = (cfg.line_limit == '0) ? LW'(1) : cfg.line_limit;
	assign kept_count  = {1'b0, newest_q - oldest_q} + (LW + 1)'(1);
	assign oldest_trim = (kept_count > {1'b0, limit}) ? newest_q - limit + LW'(1) : oldest_q;
	assign fit_sum     = {1'b0, line_q} + {1'b0, wl_q};
	assign wl_inc      = (wl_q < CW'(MAX_COLUMNS)) ? wl_q + CW'(1) : wl_q;

	always_comb begin
		state_d  = state_q;
		aft_d    = aft_q;
		fin_d    = fin_q;
		wl_d     = wl_q;
		line_d   = line_q;
		idx_d    = idx_q;
		newest_d = newest_q;
		oldest_d = oldest_q;
		op_pop   = 1'b0;
		mem_we   = 1'b0;
		gen      = 1'b0;
		gen_item = '{kind: wwr_pkg::KIND_CHAR, line_number: '0, column: '0,
			char_code: 8'd0, oldest_line: oldest_q, last: 1'b0};

		case (state_q)
			S_FETCH: begin
				op_pop = op_valid && can_step;
				if (op_pop) begin
					fin_d   = op.fin;
					state_d = op.fin ? S_FIN : S_FETCH;
					case (op.code)
						wwr_pkg::OP_CLEAR, wwr_pkg::OP_MSG_CLEAR: begin
							if (op.code == wwr_pkg::OP_CLEAR) begin
								wl_d = '0;
							end
							newest_d = newest_inc;
							oldest_d = newest_inc;
							line_d   = '0;
							gen      = 1'b1;
							gen_item.kind        = wwr_pkg::KIND_CLEARED;
							gen_item.line_number = newest_inc;
							gen_item.oldest_line = newest_inc;
						end
						wwr_pkg::OP_CHAR: begin
							if (op.ch == wwr_pkg::CH_LF) begin
								aft_d   = AFT_OPEN;
								state_d = S_CHECK;
							end else if (op.ch == wwr_pkg::CH_SPACE ||
								op.ch == wwr_pkg::CH_TAB) begin
								aft_d   = AFT_SPACE;
								state_d = S_CHECK;
							end else if (op.ch >= wwr_pkg::CH_PRINT_MIN) begin
								mem_we = (wl_q < CW'(MAX_COLUMNS));
								wl_d   = wl_inc;
								if (wl_inc >= cfg.eff_width) begin
									aft_d   = AFT_NONE;
									state_d = S_CHECK;
								end
							end
						end
						wwr_pkg::OP_END: begin
							oldest_d = oldest_trim;
							gen      = 1'b1;
							gen_item.kind        = wwr_pkg::KIND_DONE;
							gen_item.line_number = newest_q;
							gen_item.oldest_line = oldest_trim;
						end
						default: begin
						end
					endcase
				end
			end
			S_CHECK: begin
				idx_d = '0;
				if (wl_q == '0) begin
					state_d = S_AFTER;
				end else if (fit_sum > {1'b0, cfg.eff_width}) begin
					gen = 1'b1;
					gen_item.kind        = wwr_pkg::KIND_NEWLINE;
					gen_item.line_number = newest_inc;
					if (can_step) begin
						newest_d = newest_inc;
						line_d   = '0;
						state_d  = S_STREAM;
					end
				end else begin
					state_d = S_STREAM;
				end
			end
			S_STREAM: begin
				gen = 1'b1;
				gen_item.line_number = newest_q;
				gen_item.column      = line_q;
				gen_item.char_code   = rd_data_q;
				if (can_step) begin
					line_d = line_q + CW'(1);
					idx_d  = idx_q + CW'(1);
					if (idx_q + CW'(1) == wl_q) begin
						wl_d    = '0;
						state_d = S_AFTER;
					end
				end
			end
			S_AFTER: begin
				state_d = fin_q ? S_FIN : S_FETCH;
				case (aft_q)
					AFT_OPEN: begin
						gen = 1'b1;
						gen_item.kind        = wwr_pkg::KIND_NEWLINE;
						gen_item.line_number = newest_inc;
						if (can_step) begin
							newest_d = newest_inc;
							line_d   = '0;
						end else begin
							state_d = S_AFTER;
						end
					end
					AFT_SPACE: begin
						if (line_q != '0 && line_q < cfg.eff_width) begin
							gen = 1'b1;
							gen_item.line_number = newest_q;
							gen_item.column      = line_q;
							gen_item.char_code   = wwr_pkg::CH_SPACE;
							if (can_step) begin
								line_d = line_q + CW'(1);
							end else begin
								state_d = S_AFTER;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_FIN: begin
				if (can_step) begin
					state_d = S_FETCH;
				end
			end
			default: begin
				state_d = S_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_FETCH;
			aft_q        <= AFT_NONE;
			fin_q        <= 1'b0;
			wl_q         <= '0;
			line_q       <= '0;
			idx_q        <= '0;
			newest_q     <= '0;
			oldest_q     <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			aft_q    <= aft_d;
			fin_q    <= fin_d;
			wl_q     <= wl_d;
			line_q   <= line_d;
			idx_q    <= idx_d;
			newest_q <= newest_d;
			oldest_q <= oldest_d;
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (gen_fire) begin
				hold_valid_q <= 1'b1;
			end else if (move) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// Result payloads: one held back until it is known whether it closes the transaction
	always_ff @(posedge clk) begin
		if (gen_fire) begin
			hold_q <= gen_item;
		end
		if (move) begin
			out_q      <= hold_q;
			out_q.last <= fin_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			word_mem[wl_q[AW-1:0]] <= op.ch;
		end
		rd_data_q <= word_mem[idx_d[AW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_fin_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> !hold_valid_q)
		else $error("held result not drained at end of transaction");

	a_stream_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> (idx_q < wl_q))
		else $error("word read index past word length");

	a_clear_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && (op.code == wwr_pkg::OP_CLEAR || op.code == wwr_pkg::OP_MSG_CLEAR))
		|=> (oldest_q == newest_q))
		else $error("clear did not reset the oldest kept line");

	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (wl_q < cfg.eff_width || wl_q == '0 ||
			$past(cfg.eff_width) != cfg.eff_width || wl_q <= CW'(MAX_COLUMNS)))
		else $error("pending word longer than the store");

endmodule
